// ===== rtl/nsfc_pkg.sv =====
package nsfc_pkg;

    // Character codes recognized by the framer
    localparam logic [7:0] CHAR_DOLLAR  = 8'h24;
    localparam logic [7:0] CHAR_STAR    = 8'h2A;
    localparam logic [7:0] CHAR_NEWLINE = 8'h0A;

    // Register reset value
    localparam logic [7:0] MAX_FRAME_LEN_RESET = 8'd100;

    // Bytes allowed after the checksum before the newline
    localparam logic [7:0] END_SLACK = 8'd2;

    // Frame status codes
    localparam logic [2:0] STATUS_NONE     = 3'd0;
    localparam logic [2:0] STATUS_VALID    = 3'd1;
    localparam logic [2:0] STATUS_MISMATCH = 3'd2;
    localparam logic [2:0] STATUS_TOO_LONG = 3'd3;
    localparam logic [2:0] STATUS_ABORTED  = 3'd4;

    typedef struct packed {
        logic [7:0] data_byte;
        logic       in_frame;
        logic       sentence_end;
        logic [2:0] frame_status;
        logic [7:0] frame_length;
        logic [7:0] computed_check;
        logic [7:0] received_check;
    } nsfc_result_t;

endpackage

// ===== rtl/nsfc_in_if.sv =====
interface nsfc_in_if;
    logic       valid;
    logic       ready;
    logic [7:0] rx_byte;

    modport source (output valid, output rx_byte, input ready);
    modport sink (input valid, input rx_byte, output ready);
endinterface

// ===== rtl/nsfc_out_if.sv =====
interface nsfc_out_if;
    logic       valid;
    logic       ready;
    logic [7:0] data_byte;
    logic       in_frame;
    logic       sentence_end;
    logic [2:0] frame_status;
    logic [7:0] frame_length;
    logic [7:0] computed_check;
    logic [7:0] received_check;

    modport source (
        output valid, output data_byte, output in_frame, output sentence_end,
        output frame_status, output frame_length, output computed_check,
        output received_check, input ready
    );
    modport sink (
        input valid, input data_byte, input in_frame, input sentence_end,
        input frame_status, input frame_length, input computed_check,
        input received_check, output ready
    );
endinterface

// ===== rtl/nsfc_cfg_if.sv =====
interface nsfc_cfg_if;
    logic       valid;
    logic       ready;
    logic [7:0] data;

    modport source (output valid, output data, input ready);
    modport sink (input valid, input data, output ready);
endinterface

// ===== rtl/nmea_sentence_framer_checker.sv =====
// NMEA 0183 sentence framer and checksum checker.
//
// Channels:
//   rx  - request of one received byte (rx_byte), valid/ready.
//   res - one result per byte: the byte passed through with its framing tags
//         (in_frame, sentence_end, frame_status, frame_length, computed_check,
//         received_check), valid/ready.
//   cfg - write of max_frame_len, always ready; write only while idle.
// Output: the result of an accepted byte is registered in the output buffer
//   and presented on res from there.
// Throughput: one byte per cycle while res is not stalled. The framing state updates in the same
//   cycle the byte is accepted, so bytes may follow back to back.
// Stall: a two-entry output buffer holds results. With res stalled one more
//   byte is still taken; after that rx.ready drops until res takes a result.
// Reset: the framer returns to hunting for '$', the running XOR, checksum and
//   counts clear, max_frame_len returns to 100, the output buffer empties.
module nmea_sentence_framer_checker
    import nsfc_pkg::*;
(
    input  logic         clk,
    input  logic         rst_n,
    nsfc_in_if.sink      rx,
    nsfc_out_if.source   res,
    nsfc_cfg_if.sink     cfg
);

    logic [7:0]   max_frame_len_reg;
    logic         buf_ready;
    logic         in_fire;
    nsfc_result_t step_result;

    // Configuration register: take every write at once
    assign cfg.ready = 1'b1;

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
            max_frame_len_reg <= MAX_FRAME_LEN_RESET;
        else if (cfg.valid)
            max_frame_len_reg <= cfg.data;
    end

    // Accept a request whenever the output buffer has room
    assign rx.ready = buf_ready;
    assign in_fire  = rx.valid && buf_ready;

    // Framing state machine: advance on each accepted byte
    nsfc_framer u_framer (
        .clk           (clk),
        .rst_n         (rst_n),
        .in_fire       (in_fire),
        .rx_byte       (rx.rx_byte),
        .max_frame_len (max_frame_len_reg),
        .result        (step_result)
    );

    // Result register with a spare slot to absorb one result while res is stalled
    nsfc_skid u_skid (
        .clk      (clk),
        .rst_n    (rst_n),
        .in_valid (rx.valid),
        .in_ready (buf_ready),
        .in_data  (step_result),
        .res      (res)
    );

endmodule

// ===== rtl/nsfc_framer.sv =====
module nsfc_framer
    import nsfc_pkg::*;
(
    input  logic         clk,
    input  logic         rst_n,
    input  logic         in_fire,
    input  logic [7:0]   rx_byte,
    input  logic [7:0]   max_frame_len,
    output nsfc_result_t result
);

    typedef enum logic [2:0] {
        PH_SEEK = 3'd0,
        PH_STAR = 3'd1,
        PH_HI   = 3'd2,
        PH_LO   = 3'd3,
        PH_END  = 3'd4
    } phase_t;

    phase_t     phase_reg, phase_next;
    logic [7:0] xor_reg, xor_next;
    logic [7:0] check_reg, check_next;
    logic [7:0] search_reg, search_next;
    logic [7:0] length_reg, length_next;
    logic [7:0] length_bumped;
    logic [7:0] search_inc;
    logic [3:0] nibble;

    // Map one checksum character to its nibble
    function automatic logic [3:0] hex_nibble(input logic [7:0] c);
        logic [3:0] n;
        case (c) inside
            [8'h00:8'h2F]: n = 4'd0;
            [8'h30:8'h39]: n = c[3:0];
            [8'h41:8'h46]: n = 4'(c[3:0] + 4'd9);
            [8'h61:8'h66]: n = 4'(c[3:0] + 4'd9);
            default:       n = 4'd15;
        endcase
        return n;
    endfunction

    assign length_bumped = (length_reg == 8'hFF) ? length_reg : 8'(length_reg + 8'd1);
    assign search_inc    = 8'(search_reg + 8'd1);
    assign nibble        = hex_nibble(rx_byte);

    always_comb
    begin
        phase_next  = phase_reg;
        xor_next    = xor_reg;
        check_next  = check_reg;
        search_next = search_reg;
        length_next = length_reg;

        result                = '0;
        result.data_byte      = rx_byte;

        case (phase_reg)
            PH_SEEK:
            begin
                if (rx_byte == CHAR_DOLLAR)
                begin
                    result.in_frame = 1'b1;
                    xor_next        = '0;
                    search_next     = '0;
                    length_next     = 8'd1;
                    phase_next      = PH_STAR;
                end
            end
            PH_STAR:
            begin
                result.in_frame = 1'b1;
                if (rx_byte == CHAR_STAR)
                begin
                    length_next = length_bumped;
                    phase_next  = PH_HI;
                end
                else if (rx_byte == CHAR_DOLLAR)
                begin
                    // restart on a fresh start character
                    xor_next    = '0;
                    search_next = '0;
                    length_next = 8'd1;
                end
                else
                begin
                    length_next = length_bumped;
                    xor_next    = xor_reg ^ rx_byte;
                    search_next = search_inc;
                    if (search_inc >= max_frame_len)
                    begin
                        result.frame_status = STATUS_ABORTED;
                        phase_next          = PH_SEEK;
                    end
                end
            end
            PH_HI:
            begin
                result.in_frame = 1'b1;
                length_next     = length_bumped;
                check_next      = {nibble, 4'h0};
                phase_next      = PH_LO;
            end
            PH_LO:
            begin
                result.in_frame = 1'b1;
                length_next     = length_bumped;
                check_next      = check_reg | {4'h0, nibble};
                search_next     = '0;
                phase_next      = PH_END;
            end
            PH_END:
            begin
                result.in_frame = 1'b1;
                length_next     = length_bumped;
                if (rx_byte == CHAR_NEWLINE)
                begin
                    result.sentence_end   = 1'b1;
                    result.frame_length   = length_bumped;
                    result.computed_check = xor_reg;
                    result.received_check = check_reg;
                    if (length_bumped > max_frame_len)
                        result.frame_status = STATUS_TOO_LONG;
                    else if (xor_reg == check_reg)
                        result.frame_status = STATUS_VALID;
                    else
                        result.frame_status = STATUS_MISMATCH;
                    phase_next = PH_SEEK;
                end
                else
                begin
                    search_next = search_inc;
                    if (search_inc > END_SLACK)
                    begin
                        result.frame_status = STATUS_ABORTED;
                        phase_next          = PH_SEEK;
                    end
                end
            end
            default:
            begin
                phase_next = PH_SEEK;
            end
        endcase
    end

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            phase_reg  <= PH_SEEK;
            xor_reg    <= '0;
            check_reg  <= '0;
            search_reg <= '0;
            length_reg <= '0;
        end
        else if (in_fire)
        begin
            phase_reg  <= phase_next;
            xor_reg    <= xor_next;
            check_reg  <= check_next;
            search_reg <= search_next;
            length_reg <= length_next;
        end
    end

    a_end_in_frame: assert property (@(posedge clk) disable iff (!rst_n)
        result.sentence_end |-> result.in_frame)
        else $error("frame end outside a frame");

    a_end_fields_zero: assert property (@(posedge clk) disable iff (!rst_n)
        !result.sentence_end |-> (result.frame_length == 8'd0
                                  && result.computed_check == 8'd0
                                  && result.received_check == 8'd0))
        else $error("end fields set without frame end");

    a_end_returns_seek: assert property (@(posedge clk) disable iff (!rst_n)
        (in_fire && result.frame_status != STATUS_NONE) |=> phase_reg == PH_SEEK)
        else $error("framer did not return to seek after a status");

    a_abort_not_end: assert property (@(posedge clk) disable iff (!rst_n)
        (result.frame_status == STATUS_ABORTED) |-> !result.sentence_end)
        else $error("aborted frame flagged as end");

endmodule

// ===== rtl/nsfc_skid.sv =====
module nsfc_skid
    import nsfc_pkg::*;
(
    input  logic              clk,
    input  logic              rst_n,
    input  logic              in_valid,
    output logic              in_ready,
    input  nsfc_result_t      in_data,
    nsfc_out_if.source        res
);

    logic         main_valid_reg;
    nsfc_result_t main_data_reg;
    logic         skid_valid_reg;
    nsfc_result_t skid_data_reg;
    logic         out_fire;
    logic         in_fire;

    assign in_ready = !skid_valid_reg;
    assign out_fire = main_valid_reg && res.ready;
    assign in_fire  = in_valid && in_ready;

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            main_valid_reg <= 1'b0;
            skid_valid_reg <= 1'b0;
        end
        else if (skid_valid_reg)
        begin
            // drain the spare slot first
            if (out_fire)
            begin
                main_valid_reg <= 1'b1;
                skid_valid_reg <= 1'b0;
            end
        end
        else if (in_fire)
        begin
            if (!main_valid_reg || out_fire)
                main_valid_reg <= 1'b1;
            else
                skid_valid_reg <= 1'b1;
        end
        else if (out_fire)
        begin
            main_valid_reg <= 1'b0;
        end
    end

    always_ff @(posedge clk)
    begin
        if (skid_valid_reg)
        begin
            if (out_fire)
                main_data_reg <= skid_data_reg;
        end
        else if (in_fire)
        begin
            if (!main_valid_reg || out_fire)
                main_data_reg <= in_data;
            else
                skid_data_reg <= in_data;
        end
    end

    assign res.valid          = main_valid_reg;
    assign res.data_byte      = main_data_reg.data_byte;
    assign res.in_frame       = main_data_reg.in_frame;
    assign res.sentence_end   = main_data_reg.sentence_end;
    assign res.frame_status   = main_data_reg.frame_status;
    assign res.frame_length   = main_data_reg.frame_length;
    assign res.computed_check = main_data_reg.computed_check;
    assign res.received_check = main_data_reg.received_check;

    a_skid_needs_main: assert property (@(posedge clk) disable iff (!rst_n)
        skid_valid_reg |-> main_valid_reg)
        else $error("spare slot full while output empty");

    a_skid_holds: assert property (@(posedge clk) disable iff (!rst_n)
        (skid_valid_reg && !res.ready) |=> skid_valid_reg)
        else $error("spare slot lost under stall");

    a_fill_only_on_stall: assert property (@(posedge clk) disable iff (!rst_n)
        (!skid_valid_reg && in_fire && main_valid_reg && !res.ready) |=> skid_valid_reg)
        else $error("request dropped while output stalled");

endmodule
